[src/qte_pkg.sv]
package qte_pkg;

	// default pipeline depth of each vectoring unit
	localparam int CORDIC_STAGES_DEF = 24;

	// widths: raw products, combined terms, cordic datapath, angle accumulator
	localparam int PW_PROD = 35;
	localparam int TW = 37;
	localparam int CW = 40;
	localparam int ZW = 36;
	localparam int OW = 25;

	// depth of the queue between front and back
	localparam int MQ_DEPTH = 8;

	// converged inverse cordic gain in Q24, split point of the gain multiply
	localparam int INV_GAIN_W = 24;
	localparam logic [INV_GAIN_W-1:0] INV_GAIN = 24'd10188014;
	localparam int GLO = 20;

	localparam logic signed [TW-1:0] ONE_Q30 = TW'(64'sd1 << 30);
	localparam logic signed [ZW-1:0] BAM_QUARTER = ZW'(64'sd1 << 30);
	localparam logic signed [ZW-1:0] BAM_HALF = ZW'(64'sd1 << 31);

	// terms formed by the front part, one word of the middle queue
	typedef struct packed {
		logic signed [TW-1:0] u1;
		logic signed [TW-1:0] u2;
		logic signed [TW-1:0] u3;
		logic signed [TW-1:0] v;
		logic signed [TW-1:0] s;
	} terms_t;

	// arctangent of 2^-i in binary angle units (2^32 per turn)
	function automatic logic [31:0] atan_bam(input int i);
		logic [31:0] r;
		unique case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

[src/qte_front.sv]
module qte_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [31:0]      q_w,
	input  logic signed [31:0]      q_x,
	input  logic signed [31:0]      q_y,
	input  logic signed [31:0]      q_z,
	input  logic                    mq_pop,
	output logic                    mq_push,
	output qte_pkg::terms_t         mq_data
);

	localparam int PP = qte_pkg::PW_PROD;
	localparam int TW = qte_pkg::TW;
	localparam int OCC_W = $clog2(qte_pkg::MQ_DEPTH + 1);

	logic                   acc;
	logic [OCC_W-1:0]       occ_q;
	logic                   vld_s1, vld_s2;
	logic signed [63:0]     m_ww, m_wx, m_wy, m_wz, m_xy, m_xz, m_yy, m_yz, m_zz;
	logic signed [PP-1:0]   pww_s1, pwx_s1, pwy_s1, pwz_s1, pxy_s1, pxz_s1;
	logic signed [PP-1:0]   pyy_s1, pyz_s1, pzz_s1;
	qte_pkg::terms_t        t_s2;

	// words in flight up to the middle queue pop; full when the queue could overflow
	assign full = (occ_q == OCC_W'(qte_pkg::MQ_DEPTH));
	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc && !mq_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (!acc && mq_pop) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// pairwise products, floor shift by 29
	assign m_ww = q_w * q_w;
	assign m_wx = q_w * q_x;
	assign m_wy = q_w * q_y;
	assign m_wz = q_w * q_z;
	assign m_xy = q_x * q_y;
	assign m_xz = q_x * q_z;
	assign m_yy = q_y * q_y;
	assign m_yz = q_y * q_z;
	assign m_zz = q_z * q_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pww_s1 <= m_ww[63:29];
		pwx_s1 <= m_wx[63:29];
		pwy_s1 <= m_wy[63:29];
		pwz_s1 <= m_wz[63:29];
		pxy_s1 <= m_xy[63:29];
		pxz_s1 <= m_xz[63:29];
		pyy_s1 <= m_yy[63:29];
		pyz_s1 <= m_yz[63:29];
		pzz_s1 <= m_zz[63:29];
	end

	// combined terms
	always_ff @(posedge clk) begin
		t_s2.u1 <= TW'(pxy_s1) - TW'(pwz_s1);
		t_s2.u2 <= TW'(pyy_s1) + TW'(pww_s1) - qte_pkg::ONE_Q30;
		t_s2.u3 <= TW'(pyz_s1) + TW'(pwx_s1);
		t_s2.v  <= TW'(pzz_s1) + TW'(pww_s1) - qte_pkg::ONE_Q30;
		t_s2.s  <= TW'(pxz_s1) - TW'(pwy_s1);
	end

	assign mq_push = vld_s2;
	assign mq_data = t_s2;

endmodule

[src/qte_queue.sv]
module qte_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr,
	input  qte_pkg::terms_t         wr_data,
	input  logic                    rd,
	output logic                    empty,
	output qte_pkg::terms_t         rd_data
);

	localparam int DEPTH = qte_pkg::MQ_DEPTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qte_pkg::terms_t        mem_q [0:DEPTH-1];
	logic [AW-1:0]          wp_q, rp_q;
	logic [CNT_W-1:0]       cnt_q;

	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (cnt_q != CNT_W'(DEPTH) || rd))
		else $error("word written into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> cnt_q != '0)
		else $error("word read from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count lost a word");

endmodule

[src/qte_cordic.sv]
module qte_cordic #(
	parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [qte_pkg::CW-1:0] x_in,
	input  logic signed [qte_pkg::CW-1:0] y_in,
	input  logic [PW-1:0]               pass_in,
	output logic                        out_valid,
	output logic signed [qte_pkg::CW-1:0] x_out,
	output logic signed [qte_pkg::ZW-1:0] z_out,
	output logic [PW-1:0]               pass_out
);

	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;

	logic signed [CW-1:0]   x_s [0:STAGES];
	logic signed [CW-1:0]   y_s [0:STAGES];
	logic signed [ZW-1:0]   z_s [0:STAGES];
	logic [PW-1:0]          p_s [0:STAGES];
	logic                   vld_s [0:STAGES];

	// quadrant entry: left half plane turned by a quarter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= pass_in;
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= qte_pkg::BAM_QUARTER;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -qte_pkg::BAM_QUARTER;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// one micro-rotation per stage, held when y is zero
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATN = ZW'(qte_pkg::atan_bam(i));
		logic signed [CW-1:0] xs, ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i+1] <= p_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATN;
				end else if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign x_out = x_s[STAGES];
	assign z_out = z_s[STAGES];
	assign pass_out = p_s[STAGES];

endmodule

[src/qte_back.sv]
module qte_back #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mq_empty,
	input  qte_pkg::terms_t             mq_data,
	output logic                        mq_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [qte_pkg::OW-1:0] angle_a,
	output logic signed [qte_pkg::OW-1:0] angle_b,
	output logic signed [qte_pkg::OW-1:0] angle_c
);

	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;
	localparam int TW = qte_pkg::TW;
	localparam int OW = qte_pkg::OW;
	localparam int GW = qte_pkg::INV_GAIN_W;
	localparam int GLO = qte_pkg::GLO;
	localparam int GHI = CW - GLO;

	logic                   adv;
	logic                   c1_vld, c2_vld;
	logic signed [CW-1:0]   c1_mag;
	logic signed [ZW-1:0]   c1_ang, c2_ang, c3_ang;
	logic [3*TW-1:0]        c1_pass;
	logic [0:0]             c2_pass;
	logic [ZW-1:0]          c3_pass;

	logic                   vld_g1, vld_g2, vld_f1, vld_f2, vld_f3;
	logic [GLO+GW-1:0]      lo_g1;
	logic [GHI+GW-1:0]      hi_g1;
	logic signed [ZW-1:0]   ac_g1, ac_g2;
	logic signed [TW-1:0]   u3_g1, v_g1, s_g1, u3_g2, v_g2, s_g2;
	logic [63:0]            gsum;
	logic signed [CW-1:0]   mag_g2;

	logic signed [ZW-1:0]   ab1, ab2, aa_fold;
	logic signed [ZW-1:0]   aa_f1, ab_f1, ac_f1;
	logic                   na_f2, nb_f2, nc_f2;
	logic [ZW-1:0]          ma_f2, mb_f2, mc_f2;
	logic signed [OW-1:0]   oa_f3, ob_f3, oc_f3;

	// whole back pipeline moves unless the finished word is held
	assign adv = !vld_f3 || pop;
	assign mq_pop = adv && !mq_empty;
	assign empty = !vld_f3;

	// root and third angle: vectoring of (u2, u1)
	qte_cordic #(.STAGES(CORDIC_STAGES), .PW(3*TW)) u_c1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(mq_pop),
		.x_in(CW'(mq_data.u2)), .y_in(CW'(mq_data.u1)),
		.pass_in({mq_data.u3, mq_data.v, mq_data.s}),
		.out_valid(c1_vld), .x_out(c1_mag), .z_out(c1_ang), .pass_out(c1_pass)
	);

	// inverse gain multiply, split in two partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_g1 <= 1'b0;
			vld_g2 <= 1'b0;
		end else if (adv) begin
			vld_g1 <= c1_vld;
			vld_g2 <= vld_g1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_g1 <= c1_mag[GLO-1:0] * qte_pkg::INV_GAIN;
			hi_g1 <= c1_mag[CW-1:GLO] * qte_pkg::INV_GAIN;
			ac_g1 <= -c1_ang;
			u3_g1 <= c1_pass[3*TW-1:2*TW];
			v_g1 <= c1_pass[2*TW-1:TW];
			s_g1 <= c1_pass[TW-1:0];
		end
	end

	assign gsum = (64'(hi_g1) << GLO) + 64'(lo_g1);

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_g2 <= CW'(gsum >> GW);
			ac_g2 <= ac_g1;
			u3_g2 <= u3_g1;
			v_g2 <= v_g1;
			s_g2 <= s_g1;
		end
	end

	// first angle: vectoring of (root, u3)
	qte_cordic #(.STAGES(CORDIC_STAGES), .PW(1)) u_c2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_g2),
		.x_in(mag_g2), .y_in(CW'(u3_g2)),
		.pass_in(v_g2 < 0),
		.out_valid(c2_vld), .x_out(), .z_out(c2_ang), .pass_out(c2_pass)
	);

	// second angle: vectoring of (s, v)
	qte_cordic #(.STAGES(CORDIC_STAGES), .PW(ZW)) u_c3 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_g2),
		.x_in(CW'(s_g2)), .y_in(CW'(v_g2)),
		.pass_in(ac_g2),
		.out_valid(), .x_out(), .z_out(c3_ang), .pass_out(c3_pass)
	);

	// folding in binary angle units
	assign aa_fold = !c2_pass[0] ? c2_ang :
		(c2_ang >= 0) ? qte_pkg::BAM_HALF - c2_ang : -qte_pkg::BAM_HALF - c2_ang;
	assign ab1 = c3_ang - qte_pkg::BAM_QUARTER;
	assign ab2 = (ab1 >= qte_pkg::BAM_QUARTER) ? qte_pkg::BAM_HALF - ab1 : ab1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
			vld_f2 <= 1'b0;
			vld_f3 <= 1'b0;
		end else if (adv) begin
			vld_f1 <= c2_vld;
			vld_f2 <= vld_f1;
			vld_f3 <= vld_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_f1 <= aa_fold;
			ab_f1 <= (ab2 < -qte_pkg::BAM_QUARTER) ? -qte_pkg::BAM_HALF - ab2 : ab2;
			ac_f1 <= c3_pass;
		end
	end

	// sign and magnitude for truncation toward zero
	always_ff @(posedge clk) begin
		if (adv) begin
			na_f2 <= aa_f1 < 0;
			nb_f2 <= ab_f1 < 0;
			nc_f2 <= ac_f1 < 0;
			ma_f2 <= (aa_f1 < 0) ? ZW'(-aa_f1) : ZW'(aa_f1);
			mb_f2 <= (ab_f1 < 0) ? ZW'(-ab_f1) : ZW'(ab_f1);
			mc_f2 <= (ac_f1 < 0) ? ZW'(-ac_f1) : ZW'(ac_f1);
		end
	end

	// degrees in Q16: angle * 45 / 8192
	function automatic logic signed [OW-1:0] to_deg(input logic neg, input logic [ZW-1:0] m);
		logic [ZW+5:0] p;
		logic [OW-1:0] t;
		p = ((ZW+6)'(m) << 5) + ((ZW+6)'(m) << 3) + ((ZW+6)'(m) << 2) + (ZW+6)'(m);
		t = p[OW+12:13];
		return neg ? -t : t;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			oa_f3 <= to_deg(na_f2, ma_f2);
			ob_f3 <= to_deg(nb_f2, mb_f2);
			oc_f3 <= to_deg(nc_f2, mc_f2);
		end
	end

	assign angle_a = oa_f3;
	assign angle_b = ob_f3;
	assign angle_c = oc_f3;

endmodule

[src/quaternion_to_euler_angles_core.sv]
// Quaternion to three angles in Q16 degrees.
// Input side is a queue: a word (q_w, q_x, q_y, q_z, signed Q30) is taken at
// an edge where push is high and full is low. Output side is a queue too:
// angle_a, angle_b, angle_c show the oldest finished word while empty is low,
// and that word is taken at an edge where pop is high and empty is low.
// The front part registers the pairwise products, then the combined terms,
// and writes the terms into an eight-word queue. The back part runs three
// pipelined vectoring CORDIC units, two in parallel after the first, plus a
// gain multiply and three folding and scaling stages.
// One word per cycle is sustained while pop is high whenever empty is low.
// When pop stays low, the back pipeline holds as a whole; the front keeps
// taking words until the middle queue is committed, then raises full.
// Reset clears all valid bits and queue pointers: the block comes out of
// reset empty and ready, with no clearing pass.
module quaternion_to_euler_angles_core #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic signed [31:0]              q_w,
	input  logic signed [31:0]              q_x,
	input  logic signed [31:0]              q_y,
	input  logic signed [31:0]              q_z,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [qte_pkg::OW-1:0]   angle_a,
	output logic signed [qte_pkg::OW-1:0]   angle_b,
	output logic signed [qte_pkg::OW-1:0]   angle_c
);

	logic               mq_push, mq_pop, mq_empty;
	qte_pkg::terms_t    mq_wdata, mq_rdata;

	// front: products and terms
	qte_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z),
		.mq_pop(mq_pop), .mq_push(mq_push), .mq_data(mq_wdata)
	);

	// decoupling queue
	qte_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(mq_push), .wr_data(mq_wdata),
		.rd(mq_pop), .empty(mq_empty), .rd_data(mq_rdata)
	);

	// back: cordic units, folding and scaling
	qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n), .mq_empty(mq_empty), .mq_data(mq_rdata),
		.mq_pop(mq_pop), .empty(empty), .pop(pop),
		.angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c)
	);

endmodule
